### hdl/sik_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart inverse kinematics package
// Shared widths, constants, joint tables, the arctangent table and the
// structures that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sik_pkg;

    // Fixed geometry and default settings.
    localparam int LEG_COUNT        = 6;
    localparam int LEG_IDX_W        = 3;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int QUEUE_DEPTH      = 4;

    // Word widths.
    localparam int POS_W   = 19;
    localparam int PZ_W    = 21;
    localparam int ANG_IN_W = 16;
    localparam int HOME_W  = 19;
    localparam int ANG_W   = 34;
    localparam int ROT_W   = 34;
    localparam int JNT_W   = 18;
    localparam int PROD_W  = ROT_W + JNT_W;
    localparam int VEC_W   = 33;
    localparam int SQ_W    = 58;
    localparam int ROOT_W  = 29;
    localparam int DELTA_W = 20;
    localparam int CFG_IDX_W = 1;

    // CORDIC constants in Q30.
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] HALF_PI     = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;

    // Register reset values.
    localparam logic [HOME_W-1:0] HOME_LEG_RESET    = 19'd158762;
    localparam logic [HOME_W-1:0] HOME_HEIGHT_RESET = 19'd131840;

    // Saturation bounds of the delta output.
    localparam logic signed [DELTA_W+3:0] DELTA_MAX = 24'sd524287;
    localparam logic signed [DELTA_W+3:0] DELTA_MIN = -24'sd524288;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOME_LEG_LENGTH = 1'b0,
        REG_HOME_HEIGHT     = 1'b1
    } cfg_reg_t;

    // One CORDIC lane: vector, residual angle and the half-turn flip.
    typedef struct packed {
        logic signed [ANG_W-1:0] x;
        logic signed [ANG_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
    } cordic_t;

    // Platform position in 1/256 mm, z already offset by the home height.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [PZ_W-1:0]  z;
    } pos_t;

    // Rotation matrix columns needed by the legs, plus the position.
    typedef struct packed {
        logic signed [ROT_W-1:0] r00;
        logic signed [ROT_W-1:0] r01;
        logic signed [ROT_W-1:0] r10;
        logic signed [ROT_W-1:0] r11;
        logic signed [ROT_W-1:0] r20;
        logic signed [ROT_W-1:0] r21;
        pos_t                    pos;
    } rot_t;

    // Arctangent of 2^-i in Q30, truncated.
    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Upper (platform) joint coordinates in 1/256 mm.
    function automatic logic signed [JNT_W-1:0] upper_x(input logic [LEG_IDX_W-1:0] leg);
        logic signed [JNT_W-1:0] v;
        case (leg)
            3'd0: v = -18'sd12800;
            3'd1: v = 18'sd12800;
            3'd2: v = 18'sd102201;
            3'd3: v = 18'sd89401;
            3'd4: v = -18'sd89401;
            3'd5: v = -18'sd102201;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [JNT_W-1:0] upper_y(input logic [LEG_IDX_W-1:0] leg);
        logic signed [JNT_W-1:0] v;
        case (leg)
            3'd0: v = -18'sd110622;
            3'd1: v = -18'sd110622;
            3'd2: v = 18'sd44226;
            3'd3: v = 18'sd66396;
            3'd4: v = 18'sd66396;
            3'd5: v = 18'sd44226;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Lower (base) joint coordinates in 1/256 mm.
    function automatic logic signed [JNT_W-1:0] lower_x(input logic [LEG_IDX_W-1:0] leg);
        logic signed [JNT_W-1:0] v;
        case (leg)
            3'd0: v = -18'sd89401;
            3'd1: v = 18'sd89401;
            3'd2: v = 18'sd102201;
            3'd3: v = 18'sd12800;
            3'd4: v = -18'sd12800;
            3'd5: v = -18'sd102201;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [JNT_W-1:0] lower_y(input logic [LEG_IDX_W-1:0] leg);
        logic signed [JNT_W-1:0] v;
        case (leg)
            3'd0: v = -18'sd66396;
            3'd1: v = -18'sd66396;
            3'd2: v = -18'sd44226;
            3'd3: v = 18'sd110622;
            3'd4: v = 18'sd110622;
            3'd5: v = -18'sd44226;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Product of two Q30 values, floored back to Q30.
    function automatic logic signed [ROT_W-1:0] mul30(input logic signed [ROT_W-1:0] a,
                                                      input logic signed [ROT_W-1:0] b);
        logic signed [2*ROT_W-1:0] p;
        p = a * b;
        return p[ROT_W+29:30];
    endfunction

endpackage

### hdl/sik_pose_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose channel
// Valid/ready channel that carries one platform pose per request.
// ----------------------------------------------------------------------------
interface sik_pose_if;

    logic               valid;
    logic               ready;
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic signed [18:0] pos_z;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;

    modport source (output valid, pos_x, pos_y, pos_z, roll, pitch, yaw, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, roll, pitch, yaw, output ready);

endinterface

### hdl/sik_leg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leg result channel
// Valid/ready channel that carries one leg length delta per request.
// ----------------------------------------------------------------------------
interface sik_leg_if;

    logic               valid;
    logic               ready;
    logic [2:0]         leg_index;
    logic signed [19:0] leg_delta;
    logic               last_leg;

    modport source (output valid, leg_index, leg_delta, last_leg, input ready);
    modport sink   (input valid, leg_index, leg_delta, last_leg, output ready);

endinterface

### hdl/sik_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart IK front end
// Accepts poses, runs three pipelined CORDIC lanes for sine and cosine of
// roll, pitch and yaw, and builds the rotation matrix entries for the legs.
// ----------------------------------------------------------------------------
module sik_front import sik_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    sik_pose_if.sink          pose,
    input  logic [HOME_W-1:0] home_height,
    output logic              out_valid,
    output rot_t              out_data,
    input  logic              out_ready
);

    // Prepare a lane: scale the angle to Q30 and fold it into +-pi/2.
    function automatic cordic_t cordic_init(input logic signed [ANG_IN_W-1:0] ang);
        cordic_t c;
        logic signed [ANG_W-1:0] z;
        z = {ang[ANG_IN_W-1], ang, 17'b0};
        c.x = CORDIC_GAIN;
        c.y = '0;
        c.flip = 1'b0;
        if (z > HALF_PI)
        begin
            z = z - PI_Q30;
            c.flip = 1'b1;
        end
        else if (z < -HALF_PI)
        begin
            z = z + PI_Q30;
            c.flip = 1'b1;
        end
        c.z = z;
        return c;
    endfunction

    // One CORDIC rotation step by atan(2^-i).
    function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
        cordic_t n;
        n.flip = c.flip;
        if (c.z >= 0)
        begin
            n.x = c.x - (c.y >>> i);
            n.y = c.y + (c.x >>> i);
            n.z = c.z - atan_q30(i);
        end
        else
        begin
            n.x = c.x + (c.y >>> i);
            n.y = c.y - (c.x >>> i);
            n.z = c.z + atan_q30(i);
        end
        return n;
    endfunction

    logic                    adv;
    logic [CORDIC_STEPS:0]   cvld_reg;
    logic                    sc_vld_reg;
    logic                    m1_vld_reg;
    logic                    out_valid_reg;

    cordic_t                 lane_reg [0:CORDIC_STEPS][0:2];
    pos_t                    pos_reg  [0:CORDIC_STEPS];
    cordic_t                 init_next [0:2];
    logic signed [PZ_W-1:0]  pz_next;

    logic signed [ANG_W-1:0] sin_reg [0:2];
    logic signed [ANG_W-1:0] cos_reg [0:2];
    pos_t                    pos_sc_reg;

    logic signed [ROT_W-1:0] czsy_reg, szsy_reg, r00_reg, szcx_reg;
    logic signed [ROT_W-1:0] r10_reg, czcx_reg, r21_reg, r20_reg, sx_reg;
    pos_t                    pos_m1_reg;
    rot_t                    out_data_reg;

    // The whole front pipeline moves when its last stage can drain.
    assign adv        = !out_valid_reg || out_ready;
    assign pose.ready = adv;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Lane set-up for roll, pitch and yaw, and the absolute height.
    always_comb
    begin
        init_next[0] = cordic_init(pose.roll);
        init_next[1] = cordic_init(pose.pitch);
        init_next[2] = cordic_init(pose.yaw);
        pz_next = {{(PZ_W-POS_W){pose.pos_z[POS_W-1]}}, pose.pos_z}
                  + {{(PZ_W-HOME_W){1'b0}}, home_height};
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvld_reg      <= '0;
            sc_vld_reg    <= 1'b0;
            m1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cvld_reg      <= {cvld_reg[CORDIC_STEPS-1:0], pose.valid};
            sc_vld_reg    <= cvld_reg[CORDIC_STEPS];
            m1_vld_reg    <= sc_vld_reg;
            out_valid_reg <= m1_vld_reg;
        end
    end

    // Entry stage of the CORDIC pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lane_reg[0][j] <= init_next[j];
            end
            pos_reg[0].x <= pose.pos_x;
            pos_reg[0].y <= pose.pos_y;
            pos_reg[0].z <= pz_next;
        end
    end

    // One register stage per CORDIC iteration.
    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lane_reg[k][j] <= cordic_step(lane_reg[k-1][j], k - 1);
                end
                pos_reg[k] <= pos_reg[k-1];
            end
        end
    end

    // Undo the half-turn fold on sine and cosine.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sin_reg[j] <= lane_reg[CORDIC_STEPS][j].flip ? -lane_reg[CORDIC_STEPS][j].y
                                                             : lane_reg[CORDIC_STEPS][j].y;
                cos_reg[j] <= lane_reg[CORDIC_STEPS][j].flip ? -lane_reg[CORDIC_STEPS][j].x
                                                             : lane_reg[CORDIC_STEPS][j].x;
            end
            pos_sc_reg <= pos_reg[CORDIC_STEPS];
        end
    end

    // First product layer of Rz*Ry*Rx.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            czsy_reg   <= mul30(cos_reg[2], sin_reg[1]);
            szsy_reg   <= mul30(sin_reg[2], sin_reg[1]);
            r00_reg    <= mul30(cos_reg[2], cos_reg[1]);
            szcx_reg   <= mul30(sin_reg[2], cos_reg[0]);
            r10_reg    <= mul30(sin_reg[2], cos_reg[1]);
            czcx_reg   <= mul30(cos_reg[2], cos_reg[0]);
            r21_reg    <= mul30(cos_reg[1], sin_reg[0]);
            r20_reg    <= -sin_reg[1];
            sx_reg     <= sin_reg[0];
            pos_m1_reg <= pos_sc_reg;
        end
    end

    // Second product layer and the finished matrix entries.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.r00 <= r00_reg;
            out_data_reg.r01 <= mul30(czsy_reg, sx_reg) - szcx_reg;
            out_data_reg.r10 <= r10_reg;
            out_data_reg.r11 <= mul30(szsy_reg, sx_reg) + czcx_reg;
            out_data_reg.r20 <= r20_reg;
            out_data_reg.r21 <= r21_reg;
            out_data_reg.pos <= pos_m1_reg;
        end
    end

endmodule

### hdl/sik_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart IK pose queue
// Short register queue of finished rotation sets between front and back end.
// ----------------------------------------------------------------------------
module sik_queue import sik_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  rot_t in_data,
    output logic in_ready,
    output logic out_valid,
    output rot_t out_data,
    input  logic out_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rot_t             entry_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hdl/sik_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart IK back end
// Issues one leg per cycle from the queued rotation set unless the output stalls: rotated
// joint, leg vector, squared length, pipelined integer square root, delta and clamp.
// ----------------------------------------------------------------------------
module sik_back import sik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rot_t              in_data,
    output logic              in_pop,
    input  logic [HOME_W-1:0] home_leg_length,
    sik_leg_if.source         legs
);

    localparam int TR_W  = SQ_W + 2;
    localparam int LEN_W = ROOT_W + 1 - 8;

    logic                     adv;
    logic                     issue;
    logic [LEG_IDX_W-1:0]     leg_cnt_reg;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [ROOT_W:0]          rvld_reg;
    logic                     out_valid_reg;

    logic signed [PROD_W-1:0] prod_reg [0:5];
    pos_t                     s1_pos_reg;
    logic [LEG_IDX_W-1:0]     s1_leg_reg, s2_leg_reg, s3_leg_reg;

    logic signed [PROD_W:0]   sum_x, sum_y, sum_z;
    logic signed [PROD_W:0]   shx, shy, shz;
    logic signed [JNT_W-1:0]  lox, loy;
    logic signed [VEC_W-1:0]  px, py, pz, lx, ly;
    logic signed [VEC_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic signed [2*VEC_W-1:0] sqx, sqy, sqz;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;

    logic [SQ_W-1:0]          rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]        root_reg [0:ROOT_W];
    logic [LEG_IDX_W-1:0]     rleg_reg [0:ROOT_W];

    logic [ROOT_W:0]          rounded;
    logic [LEN_W-1:0]         len8;
    logic signed [DELTA_W+3:0] delta;
    logic signed [DELTA_W-1:0] delta_sat;

    logic [LEG_IDX_W-1:0]     out_leg_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;
    logic                     out_last_reg;

    // The back pipeline moves whenever the result register can take a value.
    assign adv    = !out_valid_reg || legs.ready;
    assign issue  = adv && in_valid;
    assign in_pop = issue && (leg_cnt_reg == LEG_IDX_W'(LEG_COUNT - 1));

    assign legs.valid     = out_valid_reg;
    assign legs.leg_index = out_leg_reg;
    assign legs.leg_delta = out_delta_reg;
    assign legs.last_leg  = out_last_reg;

    // Leg counter and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_cnt_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            rvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                leg_cnt_reg <= in_pop ? '0 : leg_cnt_reg + 1'b1;
            end
            if (adv)
            begin
                s1_vld_reg    <= in_valid;
                s2_vld_reg    <= s1_vld_reg;
                s3_vld_reg    <= s2_vld_reg;
                rvld_reg      <= {rvld_reg[ROOT_W-1:0], s3_vld_reg};
                out_valid_reg <= rvld_reg[ROOT_W];
            end
        end
    end

    // Rotate the upper joint: six matrix-by-coordinate products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0] <= in_data.r00 * upper_x(leg_cnt_reg);
            prod_reg[1] <= in_data.r01 * upper_y(leg_cnt_reg);
            prod_reg[2] <= in_data.r10 * upper_x(leg_cnt_reg);
            prod_reg[3] <= in_data.r11 * upper_y(leg_cnt_reg);
            prod_reg[4] <= in_data.r20 * upper_x(leg_cnt_reg);
            prod_reg[5] <= in_data.r21 * upper_y(leg_cnt_reg);
            s1_pos_reg  <= in_data.pos;
            s1_leg_reg  <= leg_cnt_reg;
        end
    end

    // Leg vector in Q16: rotated joint plus position minus base joint.
    always_comb
    begin
        lox = lower_x(s1_leg_reg);
        loy = lower_y(s1_leg_reg);
        sum_x = {prod_reg[0][PROD_W-1], prod_reg[0]} + {prod_reg[1][PROD_W-1], prod_reg[1]};
        sum_y = {prod_reg[2][PROD_W-1], prod_reg[2]} + {prod_reg[3][PROD_W-1], prod_reg[3]};
        sum_z = {prod_reg[4][PROD_W-1], prod_reg[4]} + {prod_reg[5][PROD_W-1], prod_reg[5]};
        shx = sum_x >>> 22;
        shy = sum_y >>> 22;
        shz = sum_z >>> 22;
        px = {{(VEC_W-POS_W-8){s1_pos_reg.x[POS_W-1]}}, s1_pos_reg.x, 8'b0};
        py = {{(VEC_W-POS_W-8){s1_pos_reg.y[POS_W-1]}}, s1_pos_reg.y, 8'b0};
        pz = {{(VEC_W-PZ_W-8){s1_pos_reg.z[PZ_W-1]}}, s1_pos_reg.z, 8'b0};
        lx = {{(VEC_W-JNT_W-8){lox[JNT_W-1]}}, lox, 8'b0};
        ly = {{(VEC_W-JNT_W-8){loy[JNT_W-1]}}, loy, 8'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg     <= shx[VEC_W-1:0] + px - lx;
            vy_reg     <= shy[VEC_W-1:0] + py - ly;
            vz_reg     <= shz[VEC_W-1:0] + pz;
            s2_leg_reg <= s1_leg_reg;
        end
    end

    // Squares of the three components.
    always_comb
    begin
        sqx = vx_reg * vx_reg;
        sqy = vy_reg * vy_reg;
        sqz = vz_reg * vz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg    <= sqx[SQ_W-1:0];
            sqy_reg    <= sqy[SQ_W-1:0];
            sqz_reg    <= sqz[SQ_W-1:0];
            s3_leg_reg <= s2_leg_reg;
        end
    end

    // Squared length enters the root pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= sqx_reg + sqy_reg + sqz_reg;
            root_reg[0] <= '0;
            rleg_reg[0] <= s3_leg_reg;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [TR_W-1:0] trial;
        logic [TR_W-1:0] rem_ext;

        assign rem_ext = {2'b00, rem_reg[k]};
        assign trial   = ({{(TR_W-ROOT_W){1'b0}}, root_reg[k]} << (B + 1))
                         + (TR_W'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rem_ext >= trial)
                begin
                    rem_reg[k+1]  <= rem_reg[k] - trial[SQ_W-1:0];
                    root_reg[k+1] <= root_reg[k] | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
                rleg_reg[k+1] <= rleg_reg[k];
            end
        end
    end

    // Round to 1/256 mm, subtract the home length and clamp.
    always_comb
    begin
        rounded = {1'b0, root_reg[ROOT_W]} + (ROOT_W + 1)'(128);
        len8    = rounded[ROOT_W:8];
        delta   = $signed({{(DELTA_W+4-LEN_W){1'b0}}, len8})
                  - $signed({{(DELTA_W+4-HOME_W){1'b0}}, home_leg_length});
        if (delta > DELTA_MAX)
        begin
            delta_sat = DELTA_MAX[DELTA_W-1:0];
        end
        else if (delta < DELTA_MIN)
        begin
            delta_sat = DELTA_MIN[DELTA_W-1:0];
        end
        else
        begin
            delta_sat = delta[DELTA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_leg_reg   <= rleg_reg[ROOT_W];
            out_delta_reg <= delta_sat;
            out_last_reg  <= (rleg_reg[ROOT_W] == LEG_IDX_W'(LEG_COUNT - 1));
        end
    end

endmodule

### hdl/stewart_inverse_kinematics_unit.sv
`timescale 1ns / 1ps
// A pose's legs pass the front end's CORDIC, trigonometry and product registers, the
// queue and the back end's product, vector, square, root and result registers.
// The back end issues one leg per cycle through its square-root pipeline, so one leg
// result per cycle, while a rotation set is queued and the leg receiver is ready.
// Reset clears all pipeline valid flags, the queue and the leg counter, and loads
// the home leg length and home height with their defaults.
// ----------------------------------------------------------------------------
// Stewart platform inverse kinematics unit
// Six-leg pose-to-leg-length unit: pipelined CORDIC front end, short queue,
// and a leg-serial back end with a pipelined integer square root.
// ----------------------------------------------------------------------------
module stewart_inverse_kinematics_unit import sik_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    sik_pose_if.sink             pose,
    sik_leg_if.source            legs,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HOME_W-1:0]    cfg_data
);

    logic [HOME_W-1:0] home_leg_length_reg;
    logic [HOME_W-1:0] home_height_reg;

    logic front_valid;
    rot_t front_data;
    logic front_ready;
    logic q_valid;
    rot_t q_data;
    logic q_pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_leg_length_reg <= HOME_LEG_RESET;
            home_height_reg     <= HOME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HOME_LEG_LENGTH: home_leg_length_reg <= cfg_data;
                REG_HOME_HEIGHT:     home_height_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Trigonometry and rotation matrix.
    sik_front #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pose        (pose),
        .home_height (home_height_reg),
        .out_valid   (front_valid),
        .out_data    (front_data),
        .out_ready   (front_ready)
    );

    // Decoupling queue.
    sik_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .in_ready  (front_ready),
        .out_valid (q_valid),
        .out_data  (q_data),
        .out_pop   (q_pop)
    );

    // Per-leg length computation.
    sik_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (q_valid),
        .in_data         (q_data),
        .in_pop          (q_pop),
        .home_leg_length (home_leg_length_reg),
        .legs            (legs)
    );

endmodule

### tb/sv/sik_leg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart inverse kinematics leg checker
// Watches the pose, leg and register ports and predicts the six leg length
// deltas of every accepted pose. It compares each accepted leg result, field
// by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sik_leg_checker import sik_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    sik_pose_if                  pose,
    sik_leg_if                   legs,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HOME_W-1:0]    cfg_data,
    output int                   errors,
    output int                   pending
);

    localparam int STEPS = CORDIC_STEPS_DEF;

    typedef struct {
        logic [2:0]         leg_index;
        logic signed [19:0] leg_delta;
        logic               last_leg;
    } leg_result_t;

    leg_result_t   leg_queue[$];
    longint        leg_len_home;
    longint        plat_height;

    // Joint coordinates in 1/256 mm, legs 0 to 5.
    const longint up_x[6] = '{-12800, 12800, 102201, 89401, -89401, -102201};
    const longint up_y[6] = '{-110622, -110622, 44226, 66396, 66396, 44226};
    const longint lo_x[6] = '{-89401, 89401, 102201, 12800, -12800, -102201};
    const longint lo_y[6] = '{-66396, -66396, -44226, 110622, 110622, -44226};
    const longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
        524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023,
        511, 255, 127};

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // Sine and cosine in Q30 of an angle in 2^-13 rad.
    function automatic void angle_trig(input longint ang, output longint s,
                                       output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = ang * 131072;
        x = 652032874;
        y = 0;
        flip = 0;
        // Angles past a quarter turn are folded by half a turn.
        if (z > 64'sd1686629713)
        begin
            z = z - 64'sd3373259426;
            flip = 1;
        end
        else if (z < -64'sd1686629713)
        begin
            z = z + 64'sd3373259426;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_tab[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_tab[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Predicts the six leg deltas of one pose and queues them in leg order.
    function automatic void predict_legs(longint px_in, longint py_in, longint pz_in,
                                         longint ro, longint pi_, longint ya);
        longint px, py, pz, sx, cx, sy, cy, sz, cz, czsy, szsy;
        longint r00, r01, r10, r11, r20, r21, vx, vy, vz, len8, d;
        longint unsigned sq;
        leg_result_t res;
        px = px_in * 256;
        py = py_in * 256;
        pz = (pz_in + plat_height) * 256;
        angle_trig(ro, sx, cx);
        angle_trig(pi_, sy, cy);
        angle_trig(ya, sz, cz);
        czsy = qmul(cz, sy);
        szsy = qmul(sz, sy);
        r00 = qmul(cz, cy);
        r01 = qmul(czsy, sx) - qmul(sz, cx);
        r10 = qmul(sz, cy);
        r11 = qmul(szsy, sx) + qmul(cz, cx);
        r20 = -sy;
        r21 = qmul(cy, sx);
        for (int i = 0; i < 6; i++)
        begin
            vx = ((r00 * up_x[i] + r01 * up_y[i]) >>> 22) + px - lo_x[i] * 256;
            vy = ((r10 * up_x[i] + r11 * up_y[i]) >>> 22) + py - lo_y[i] * 256;
            vz = ((r20 * up_x[i] + r21 * up_y[i]) >>> 22) + pz;
            sq = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
            len8 = (int_sqrt(sq) + 128) >>> 8;
            d = len8 - leg_len_home;
            if (d > 524287)
                d = 524287;
            if (d < -524288)
                d = -524288;
            res.leg_index = 3'(i);
            res.leg_delta = 20'(d);
            res.last_leg  = (i == 5);
            leg_queue.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t ns: leg result %s mismatch: got %0d, expected %0d",
                 $time, what, got, want);
        errors++;
    endtask

    assign pending = leg_queue.size();

    // Track the registers, predict on each pose request, check each leg request.
    always @(posedge clk or negedge rst_n)
    begin
        leg_result_t want;
        if (!rst_n)
        begin
            leg_len_home <= HOME_LEG_RESET;
            plat_height  <= HOME_HEIGHT_RESET;
            leg_queue.delete();
        end
        else
        begin
            if (pose.valid && pose.ready)
                predict_legs(pose.pos_x, pose.pos_y, pose.pos_z,
                             pose.roll, pose.pitch, pose.yaw);
            if (legs.valid && legs.ready)
            begin
                if (leg_queue.size() == 0)
                begin
                    $display("%0t ns: leg result with no pose waiting", $time);
                    errors++;
                end
                else
                begin
                    want = leg_queue.pop_front();
                    if (legs.leg_index !== want.leg_index)
                        report_mismatch("leg_index", legs.leg_index, want.leg_index);
                    if (legs.leg_delta !== want.leg_delta)
                        report_mismatch("leg_delta", legs.leg_delta, want.leg_delta);
                    if (legs.last_leg !== want.last_leg)
                        report_mismatch("last_leg", legs.last_leg, want.last_leg);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_HOME_LEG_LENGTH)
                    leg_len_home <= cfg_data;
                else if (cfg_index == REG_HOME_HEIGHT)
                    plat_height <= cfg_data;
            end
        end
    end

    initial errors = 0;

endmodule

### tb/sv/tb_stewart_inverse_kinematics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stewart inverse kinematics unit testbench
// Drives directed and random poses through four traffic phases and several
// register settings; a checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module tb_stewart_inverse_kinematics_unit;
    import sik_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HOME_W-1:0]    cfg_data;
    int                   errors;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   idle_cycles;
    int                   poses_sent;

    sik_pose_if pose ();
    sik_leg_if  legs ();

    stewart_inverse_kinematics_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .legs      (legs),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sik_leg_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .legs      (legs),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Receiver stalls at random.
    always @(negedge clk)
        legs.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: cycles without any request moving.
    always @(posedge clk)
    begin
        if ((pose.valid && pose.ready) || (legs.valid && legs.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d leg results outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_pose(input logic [18:0] x, input logic [18:0] y,
                             input logic [18:0] z, input logic [15:0] ro,
                             input logic [15:0] pt, input logic [15:0] ya);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pose.valid <= 1'b0;
            @(negedge clk);
        end
        pose.valid <= 1'b1;
        pose.pos_x <= x;
        pose.pos_y <= y;
        pose.pos_z <= z;
        pose.roll  <= ro;
        pose.pitch <= pt;
        pose.yaw   <= ya;
        do
            @(posedge clk);
        while (!pose.ready);
        @(negedge clk);
        poses_sent++;
    endtask

    // Waits until every leg result is back, then lets the pipeline settle.
    task automatic drain;
        pose.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [HOME_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_pose;
        logic [18:0] p[3];
        logic [15:0] a[3];
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(3))
                0: p[k] = 19'($urandom);
                default: p[k] = 19'($signed(21'($urandom_range(40000))) - 20000);
            endcase
            if ($urandom_range(4) == 0)
                a[k] = 16'($urandom);
            else
                a[k] = 16'($urandom_range(51472) - 25736);
        end
        send_pose(p[0], p[1], p[2], a[0], a[1], a[2]);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_HOME_LEG_LENGTH;
        cfg_data       = '0;
        pose.valid     = 1'b0;
        pose.pos_x     = '0;
        pose.pos_y     = '0;
        pose.pos_z     = '0;
        pose.roll      = '0;
        pose.pitch     = '0;
        pose.yaw       = '0;
        legs.ready     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        poses_sent     = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed poses under reset register values.
        send_pose(0, 0, 0, 0, 0, 0);
        send_pose(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 16'sd25736, 16'sd25736, 16'sd25736);
        send_pose(19'h40000, 19'h40000, 19'h40000, -16'sd25736, -16'sd25736, -16'sd25736);
        send_pose(19'h3FFFF, 0, 0, 0, 0, 0);
        send_pose(0, 19'h40000, 0, 0, 0, 0);
        send_pose(0, 0, 19'h40000, 0, 0, 0);
        send_pose(0, 0, 0, 16'sd12868, 0, 0);
        send_pose(0, 0, 0, 0, -16'sd12868, 16'sd12869);
        send_pose(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_pose(0, 0, 0, 16'h8000, 16'h7FFF, 16'h8000);
        send_pose(1000, -1000, 2000, 16'sd25736, -16'sd12000, 16'sd5000);
        send_pose(19'h3FFFF, 19'h3FFFF, 19'h3FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        drain();

        // Four traffic phases, each under its own register setting.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_reg(REG_HOME_LEG_LENGTH, 19'd0);
                    write_reg(REG_HOME_HEIGHT, 19'd0);
                end
                1:
                begin
                    send_idle_pct = 73; recv_stall_pct = 0;
                    write_reg(REG_HOME_LEG_LENGTH, 19'h7FFFF);
                    write_reg(REG_HOME_HEIGHT, 19'h7FFFF);
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 73;
                    write_reg(REG_HOME_LEG_LENGTH, 19'($urandom));
                    write_reg(REG_HOME_HEIGHT, 19'($urandom));
                end
                default:
                begin
                    send_idle_pct = 19; recv_stall_pct = 19;
                    write_reg(REG_HOME_LEG_LENGTH, HOME_LEG_RESET);
                    write_reg(REG_HOME_HEIGHT, HOME_HEIGHT_RESET);
                end
            endcase
            for (int n = 0; n < 112; n++)
            begin
                send_random_pose();
                // Mid-way through the last phase, hold off until the unit has emptied.
                if (n == 56 && phase == 3)
                begin
                    pose.valid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        $display("Sent %0d poses over four traffic phases and five register settings,",
                 poses_sent);
        $display("including extreme positions, folded angles and saturated deltas.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### stewart_inverse_kinematics_unit.f
hdl/sik_pkg.sv
hdl/sik_pose_if.sv
hdl/sik_leg_if.sv
hdl/sik_front.sv
hdl/sik_queue.sv
hdl/sik_back.sv
hdl/stewart_inverse_kinematics_unit.sv
tb/sv/sik_leg_checker.sv
tb/sv/tb_stewart_inverse_kinematics_unit.sv
